// ===== src/lbc_pkg.sv =====
// Package for the LED blink controller: sizes, command codes and the
// payload structs of the command and result channels. No dependencies.
`default_nettype none
package lbc_pkg;

	localparam int LED_COUNT   = 8;
	localparam int PERIOD_BITS = 16;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [LED_COUNT-1:0]   ACTIVITY_MASK_RST = LED_COUNT'(1);
	localparam logic [PERIOD_BITS-1:0] PERIOD_ONE        = PERIOD_BITS'(1);

	// Register indexes (byte address / 4)
	localparam logic REG_ACTIVITY_MASK = 1'b0;

	// Command codes
	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_ON_CANCEL  = 3'd1;
	localparam logic [2:0] CMD_ON_KEEP    = 3'd2;
	localparam logic [2:0] CMD_OFF_CANCEL = 3'd3;
	localparam logic [2:0] CMD_OFF_KEEP   = 3'd4;
	localparam logic [2:0] CMD_BLINK      = 3'd5;
	localparam logic [2:0] CMD_UNBLINK    = 3'd6;
	localparam logic [2:0] CMD_TOGGLE     = 3'd7;

	typedef struct packed {
		logic [2:0]             cmd;
		logic [LED_COUNT-1:0]   led_sel;
		logic [PERIOD_BITS-1:0] on_ticks;
		logic [PERIOD_BITS-1:0] off_ticks;
		logic [PERIOD_BITS-1:0] blink_time;
	} cmd_item_t;

	typedef struct packed {
		logic [LED_COUNT-1:0] led_drive;
		logic                 blinking;
	} led_result_t;

	// Control from the pipeline to the engine
	typedef struct packed {
		logic                 step;
		logic [LED_COUNT-1:0] activity_mask;
	} eng_ctrl_t;

endpackage
`default_nettype wire

// ===== src/lbc_regs.sv =====
// APB register block of the LED blink controller: holds activity_mask.
// Depends on lbc_pkg.
`default_nettype none
module lbc_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lbc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [lbc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [lbc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready,
	output logic      [lbc_pkg::LED_COUNT-1:0]     activity_mask
);

	logic [lbc_pkg::LED_COUNT-1:0] activity_mask_q;
	logic                          reg_sel;
	logic                          wr_en;

	// Word index lives above the two byte-offset bits
	assign reg_sel = (paddr[2] == lbc_pkg::REG_ACTIVITY_MASK);
	assign wr_en   = psel && penable && pwrite && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activity_mask_q <= lbc_pkg::ACTIVITY_MASK_RST;
		end else if (wr_en) begin
			activity_mask_q <= pwdata[lbc_pkg::LED_COUNT-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[lbc_pkg::LED_COUNT-1:0] = activity_mask_q;
		end
	end

	assign pready        = 1'b1;
	assign activity_mask = activity_mask_q;

endmodule
`default_nettype wire

// ===== src/lbc_engine.sv =====
// Blink state and command decode of the LED blink controller. Computes the
// new LED vector for one command in a single pass. Depends on lbc_pkg.
`default_nettype none
module lbc_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lbc_pkg::eng_ctrl_t ctrl,
	input  wire lbc_pkg::cmd_item_t item,
	output lbc_pkg::led_result_t    result
);

	logic [lbc_pkg::LED_COUNT-1:0]   lit_leds_q, lit_leds_d;
	logic                            act_phase_q, act_phase_d;
	logic [lbc_pkg::LED_COUNT-1:0]   blink_leds_q, blink_leds_d;
	logic [lbc_pkg::PERIOD_BITS-1:0] on_len_q, on_len_d;
	logic [lbc_pkg::PERIOD_BITS-1:0] off_len_q, off_len_d;
	logic [lbc_pkg::PERIOD_BITS-1:0] time_left_q, time_left_d;
	logic                            lit_phase_q, lit_phase_d;
	logic                            pending_q, pending_d;
	logic [lbc_pkg::PERIOD_BITS-1:0] countdown_q, countdown_d;

	always_comb begin
		lit_leds_d   = lit_leds_q;
		act_phase_d  = act_phase_q;
		blink_leds_d = blink_leds_q;
		on_len_d     = on_len_q;
		off_len_d    = off_len_q;
		time_left_d  = time_left_q;
		lit_phase_d  = lit_phase_q;
		pending_d    = pending_q;
		countdown_d  = countdown_q;

		case (item.cmd)
			lbc_pkg::CMD_TICK: begin
				if (pending_q) begin
					if (countdown_q <= lbc_pkg::PERIOD_ONE) begin
						// Phase over: flip and re-arm or finish
						countdown_d = '0;
						pending_d   = 1'b0;
						if (lit_phase_q) begin
							lit_leds_d  = lit_leds_q & ~blink_leds_q;
							lit_phase_d = 1'b0;
							if (time_left_q == '0) begin
								countdown_d = off_len_q;
								pending_d   = 1'b1;
							end else if (time_left_q > on_len_q) begin
								time_left_d = time_left_q - on_len_q;
								countdown_d = off_len_q;
								pending_d   = 1'b1;
							end
						end else begin
							lit_leds_d  = lit_leds_q | blink_leds_q;
							lit_phase_d = 1'b1;
							if (time_left_q == '0) begin
								countdown_d = on_len_q;
								pending_d   = 1'b1;
							end else if (time_left_q > off_len_q) begin
								time_left_d = time_left_q - off_len_q;
								countdown_d = on_len_q;
								pending_d   = 1'b1;
							end else begin
								// Duration used up: leave blink LEDs dark
								lit_leds_d  = lit_leds_q & ~blink_leds_q;
								lit_phase_d = 1'b0;
							end
						end
					end else begin
						countdown_d = countdown_q - lbc_pkg::PERIOD_ONE;
					end
				end
			end
			lbc_pkg::CMD_ON_CANCEL: begin
				pending_d  = 1'b0;
				lit_leds_d = lit_leds_q | item.led_sel;
			end
			lbc_pkg::CMD_ON_KEEP: begin
				lit_leds_d = lit_leds_q | item.led_sel;
			end
			lbc_pkg::CMD_OFF_CANCEL: begin
				pending_d  = 1'b0;
				lit_leds_d = lit_leds_q & ~item.led_sel;
			end
			lbc_pkg::CMD_OFF_KEEP: begin
				lit_leds_d = lit_leds_q & ~item.led_sel;
			end
			lbc_pkg::CMD_BLINK: begin
				lit_leds_d   = lit_leds_q | item.led_sel;
				lit_phase_d  = 1'b1;
				on_len_d     = (item.on_ticks == '0) ? lbc_pkg::PERIOD_ONE : item.on_ticks;
				off_len_d    = (item.off_ticks == '0) ? lbc_pkg::PERIOD_ONE : item.off_ticks;
				blink_leds_d = item.led_sel;
				time_left_d  = item.blink_time;
				countdown_d  = (item.on_ticks == '0) ? lbc_pkg::PERIOD_ONE : item.on_ticks;
				pending_d    = 1'b1;
			end
			lbc_pkg::CMD_UNBLINK: begin
				blink_leds_d = blink_leds_q & ~item.led_sel;
				if ((blink_leds_q & ~item.led_sel) == '0) begin
					pending_d = 1'b0;
				end
			end
			lbc_pkg::CMD_TOGGLE: begin
				if (act_phase_q) begin
					lit_leds_d  = lit_leds_q | ctrl.activity_mask;
					act_phase_d = 1'b0;
				end else begin
					lit_leds_d  = lit_leds_q & ~ctrl.activity_mask;
					act_phase_d = 1'b1;
				end
			end
			default: begin
				lit_leds_d = lit_leds_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_leds_q   <= '0;
			act_phase_q  <= 1'b0;
			blink_leds_q <= '0;
			on_len_q     <= lbc_pkg::PERIOD_ONE;
			off_len_q    <= lbc_pkg::PERIOD_ONE;
			time_left_q  <= '0;
			lit_phase_q  <= 1'b0;
			pending_q    <= 1'b0;
			countdown_q  <= '0;
		end else if (ctrl.step) begin
			lit_leds_q   <= lit_leds_d;
			act_phase_q  <= act_phase_d;
			blink_leds_q <= blink_leds_d;
			on_len_q     <= on_len_d;
			off_len_q    <= off_len_d;
			time_left_q  <= time_left_d;
			lit_phase_q  <= lit_phase_d;
			pending_q    <= pending_d;
			countdown_q  <= countdown_d;
		end
	end

	assign result.led_drive = lit_leds_d;
	assign result.blinking  = pending_d;

endmodule
`default_nettype wire

// ===== src/led_blink_controller_core.sv =====
// A command accepted into item_s1 drives the engine, whose result is registered in res_s2.
// Throughput: one command per cycle; the command register and the blink
// state update in one pass, so a new command enters every cycle unless stalled.
// Back-pressure on the result stalls the command register, then in_ready.
// Reset (arst_n low) clears the blink state, LEDs and pipeline; activity_mask=1.
// Depends on lbc_pkg, lbc_regs, lbc_engine.
`default_nettype none
module led_blink_controller_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire lbc_pkg::cmd_item_t             in_item,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output lbc_pkg::led_result_t                out_item,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lbc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [lbc_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [lbc_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);

	logic                          vld_s1;
	lbc_pkg::cmd_item_t            item_s1;
	logic                          vld_s2;
	lbc_pkg::led_result_t          res_s2;
	logic                          advance;
	logic [lbc_pkg::LED_COUNT-1:0] activity_mask;
	lbc_pkg::eng_ctrl_t            eng_ctrl;
	lbc_pkg::led_result_t          eng_res;

	assign advance  = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || advance;

	assign eng_ctrl.step          = vld_s1 && advance;
	assign eng_ctrl.activity_mask = activity_mask;

	lbc_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.activity_mask (activity_mask)
	);

	lbc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (eng_ctrl),
		.item   (item_s1),
		.result (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (advance) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (eng_ctrl.step) begin
			res_s2 <= eng_res;
		end
	end

	assign out_valid = vld_s2;
	assign out_item  = res_s2;

endmodule
`default_nettype wire

// ===== src/lbc_checker.sv =====
// Port-level checker for led_blink_controller_core, bound to the top level.
// Depends on lbc_pkg and led_blink_controller_core.
`default_nettype none
module lbc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire lbc_pkg::led_result_t           out_item,
	input wire logic                           psel,
	input wire logic                           penable,
	input wire logic                           pwrite,
	input wire logic [lbc_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [lbc_pkg::APB_DATA_W-1:0] pwdata,
	input wire logic [lbc_pkg::APB_DATA_W-1:0] prdata
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Input side only blocks when a result is waiting and not taken
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output stall");

	// A register write reads back on the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[2] == lbc_pkg::REG_ACTIVITY_MASK) |=>
		(paddr[2] != lbc_pkg::REG_ACTIVITY_MASK) ||
		(prdata[lbc_pkg::LED_COUNT-1:0] == $past(pwdata[lbc_pkg::LED_COUNT-1:0])))
		else $error("activity_mask readback mismatch");

	// Unused register bits read as zero
	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[lbc_pkg::APB_DATA_W-1:lbc_pkg::LED_COUNT] == '0)
		else $error("prdata upper bits not zero");

endmodule

bind led_blink_controller_core lbc_checker u_lbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
`default_nettype wire

// ===== tb/led_blink_controller_core_tb.sv =====
// Testbench for led_blink_controller_core: a directed command table, then random
// command streams with blink bursts under several activity masks, all checked against typed-in
// results or a behavioral LED/blink predictor. Depends on lbc_pkg and the core RTL.
module led_blink_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lbc_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ACT_MASK_ADDR = APB_ADDR_W'(4 * REG_ACTIVITY_MASK);
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_CMDS = 350;

	typedef struct packed {
		cmd_item_t   item;
		logic        has_fixed;
		led_result_t fixed_res;
	} stim_row_t;

	// Expected results are typed in where they follow at a glance; 0 means predicted.
	localparam stim_row_t DIR_TAB [23] = '{
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_TICK,       8'hff, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_TOGGLE,     8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_TOGGLE,     8'hff, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{8'h01, 1'b0}},
		'{'{CMD_ON_CANCEL,  8'hff, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'hff, 1'b0}},
		'{'{CMD_OFF_KEEP,   8'hff, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_BLINK,      8'h0f, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'h0f, 1'b1}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b1}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'h0f, 1'b1}},
		'{'{CMD_ON_KEEP,    8'hf0, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'hff, 1'b1}},
		'{'{CMD_OFF_CANCEL, 8'h0f, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'hf0, 1'b0}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'hf0, 1'b0}},
		'{'{CMD_BLINK,      8'haa, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{8'hfa, 1'b1}},
		'{'{CMD_UNBLINK,    8'h0f, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'hfa, 1'b1}},
		'{'{CMD_UNBLINK,    8'hf0, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'hfa, 1'b0}},
		'{'{CMD_BLINK,      8'h55, 16'h0002, 16'h0003, 16'h0004}, 1'b1, '{8'hff, 1'b1}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_BLINK,      8'h03, 16'h0001, 16'h0001, 16'h0001}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,       8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	cmd_item_t             in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	led_result_t           out_item;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Predicted controller state, reset values as after arst_n
	logic [LED_COUNT-1:0]   act_mask = ACTIVITY_MASK_RST;
	logic [LED_COUNT-1:0]   led_lit = '0;
	logic                   act_phase = 1'b0;
	logic [LED_COUNT-1:0]   blink_set = '0;
	logic [PERIOD_BITS-1:0] on_len = PERIOD_ONE;
	logic [PERIOD_BITS-1:0] off_len = PERIOD_ONE;
	logic [PERIOD_BITS-1:0] dur_left = '0;
	logic                   lit_phase = 1'b0;
	logic                   blink_pending = 1'b0;
	logic [PERIOD_BITS-1:0] phase_count = '0;

	led_result_t led_expect_q [$];
	led_result_t led_want;
	logic        quiet = 1'b0;
	int          errors = 0;
	int          cmd_count = 0;
	int          results_seen = 0;
	int          blink_starts = 0;
	int          phase_ends = 0;
	int          mask_writes = 0;

	led_blink_controller_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void arm_phase(input logic [PERIOD_BITS-1:0] ticks);
		phase_count = ticks;
		blink_pending = 1'b1;
	endfunction

	function automatic void blink_phase_end();
		blink_pending = 1'b0;
		phase_ends++;
		if (lit_phase) begin
			led_lit &= ~blink_set;
			lit_phase = 1'b0;
			if (dur_left == '0) begin
				arm_phase(off_len);
			end else if (dur_left > on_len) begin
				dur_left -= on_len;
				arm_phase(off_len);
			end
		end else begin
			led_lit |= blink_set;
			lit_phase = 1'b1;
			if (dur_left == '0) begin
				arm_phase(on_len);
			end else if (dur_left > off_len) begin
				dur_left -= off_len;
				arm_phase(on_len);
			end else begin
				// duration used up in the dark phase: leave blink LEDs off
				led_lit &= ~blink_set;
				lit_phase = 1'b0;
			end
		end
	endfunction

	function automatic led_result_t led_step(input cmd_item_t c);
		led_result_t r;
		case (c.cmd)
			CMD_TICK: begin
				if (blink_pending) begin
					if (phase_count <= PERIOD_ONE) begin
						phase_count = '0;
						blink_phase_end();
					end else begin
						phase_count--;
					end
				end
			end
			CMD_ON_CANCEL: begin
				blink_pending = 1'b0;
				led_lit |= c.led_sel;
			end
			CMD_ON_KEEP: led_lit |= c.led_sel;
			CMD_OFF_CANCEL: begin
				blink_pending = 1'b0;
				led_lit &= ~c.led_sel;
			end
			CMD_OFF_KEEP: led_lit &= ~c.led_sel;
			CMD_BLINK: begin
				led_lit |= c.led_sel;
				lit_phase = 1'b1;
				on_len = (c.on_ticks == '0) ? PERIOD_ONE : c.on_ticks;
				off_len = (c.off_ticks == '0) ? PERIOD_ONE : c.off_ticks;
				blink_set = c.led_sel;
				dur_left = c.blink_time;
				arm_phase(on_len);
				blink_starts++;
			end
			CMD_UNBLINK: begin
				blink_set &= ~c.led_sel;
				if (blink_set == '0)
					blink_pending = 1'b0;
			end
			CMD_TOGGLE: begin
				if (act_phase)
					led_lit |= act_mask;
				else
					led_lit &= ~act_mask;
				act_phase = ~act_phase;
			end
			default: begin
			end
		endcase
		r.led_drive = led_lit;
		r.blinking = blink_pending;
		return r;
	endfunction

	// Mostly short periods so blinks expire often, with full-width values now and then
	function automatic logic [PERIOD_BITS-1:0] rand_ticks(input int unsigned short_max);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return PERIOD_BITS'($urandom_range(short_max, 0));
		else if (r < 90)
			return PERIOD_BITS'($urandom_range(60, 0));
		return PERIOD_BITS'($urandom);
	endfunction

	function automatic cmd_item_t make_cmd(input logic [2:0] op);
		cmd_item_t c;
		c.cmd = op;
		c.led_sel = LED_COUNT'($urandom);
		if (op == CMD_BLINK) begin
			c.on_ticks = rand_ticks(5);
			c.off_ticks = rand_ticks(5);
			c.blink_time = rand_ticks(30);
		end else begin
			c.on_ticks = PERIOD_BITS'($urandom);
			c.off_ticks = PERIOD_BITS'($urandom);
			c.blink_time = PERIOD_BITS'($urandom);
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_item_t c, input logic has_fixed,
			input led_result_t fixed_res);
		led_result_t res;
		while (!quiet && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// transaction accepted at this edge
		res = led_step(c);
		led_expect_q.push_back(has_fixed ? fixed_res : res);
		cmd_count++;
	endtask

	task automatic run_random(input int n);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 12) begin
				// blink followed by a train of ticks, with a few other commands mixed in
				send_cmd(make_cmd(CMD_BLINK), 1'b0, '0);
				sent++;
				burst = $urandom_range(30, 3);
				repeat (burst) begin
					if ($urandom_range(99) < 10)
						send_cmd(make_cmd(3'($urandom_range(7, 1))), 1'b0, '0);
					else
						send_cmd(make_cmd(CMD_TICK), 1'b0, '0);
					sent++;
				end
			end else begin
				send_cmd(make_cmd(3'($urandom)), 1'b0, '0);
				sent++;
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (led_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_activity_mask(input logic [LED_COUNT-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ACT_MASK_ADDR;
		pwdata <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// read back with a second transfer
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(val)) begin
			$error("activity_mask: expected %h, got %h", APB_DATA_W'(val), prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		act_mask = val;
		mask_writes++;
	endtask

	always @(posedge clk)
		out_ready <= quiet || ($urandom_range(99) >= 16);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (led_expect_q.size() == 0) begin
				$error("unexpected result: led_drive %h blinking %b",
					out_item.led_drive, out_item.blinking);
				errors++;
			end else begin
				led_want = led_expect_q.pop_front();
				results_seen++;
				if (out_item.led_drive !== led_want.led_drive) begin
					$error("led_drive: expected %h, got %h", led_want.led_drive,
						out_item.led_drive);
					errors++;
				end
				if (out_item.blinking !== led_want.blinking) begin
					$error("blinking: expected %b, got %b", led_want.blinking,
						out_item.blinking);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i])
			send_cmd(DIR_TAB[i].item, DIR_TAB[i].has_fixed, DIR_TAB[i].fixed_res);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: set_activity_mask('0);
				1: set_activity_mask('1);
				2: set_activity_mask(LED_COUNT'(1) << (LED_COUNT - 1));
				default: set_activity_mask(LED_COUNT'($urandom));
			endcase
			// one phase runs back to back with no gaps on either side
			quiet = (ph == 2);
			run_random(PHASE_CMDS);
			drain();
		end
		quiet = 1'b0;

		$display("run covered %0d commands and %0d results: %0d blinks started, %0d phase ends",
			cmd_count, results_seen, blink_starts, phase_ends);
		$display("activity mask written %0d times, including all-zero and all-one",
			mask_writes);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lbc_pkg.sv
src/lbc_regs.sv
src/lbc_engine.sv
src/led_blink_controller_core.sv
src/lbc_checker.sv
tb/led_blink_controller_core_tb.sv
